// ===== sv/ied_pkg.sv =====
package ied_pkg;

	localparam int CORE_COUNT = 16;
	localparam int CORE_IDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
	localparam logic [5:0] CORE_LIMIT = 6'(CORE_COUNT);

	typedef logic [CORE_COUNT-1:0] map_t;
	typedef logic [CORE_IDX_W-1:0] idx_t;

	localparam logic [1:0] CMD_NOTIFY = 2'd0;
	localparam logic [1:0] CMD_DROP   = 2'd1;
	localparam logic [1:0] CMD_WAIT   = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_BAD_TARGET = 2'd1;
	localparam logic [1:0] ST_SELF       = 2'd2;
	localparam logic [1:0] ST_BLOCK      = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] requester_core;
		logic [5:0] target_core;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        is_dispatch;
		logic [3:0]  source_core;
		logic [15:0] dropped_mask;
		logic        last;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic req_load;
		logic work_load;
		logic emit_single;
		logic emit_disp;
		logic emit_final;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] command;
		logic       req_bad;
		logic       blocked;
		logic       pend_nz;
		logic       out_free;
	} dp_sts_t;

	function automatic idx_t lowest_idx(map_t m);
		idx_t r;
		r = '0;
		for (int i = CORE_COUNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = idx_t'(i);
			end
		end
		return r;
	endfunction

	function automatic map_t onehot_of(idx_t i);
		return map_t'(1) << i;
	endfunction

	function automatic logic [3:0] src_field(idx_t i);
		logic [5:0] w;
		w = 6'(i);
		return w[3:0];
	endfunction

	function automatic logic [15:0] drop_field(map_t m);
		logic [31:0] w;
		w = 32'(m);
		return w[15:0];
	endfunction

endpackage

// ===== sv/ied_dp.sv =====
module ied_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  ied_pkg::req_t    req,
	input  logic             rsp_stall,
	output logic             rsp_valid,
	output ied_pkg::rsp_t    rsp,
	input  ied_pkg::dp_cmd_t cmd,
	output ied_pkg::dp_sts_t sts
);
	import ied_pkg::*;

	req_t req_q;
	map_t pend_q [CORE_COUNT];
	map_t hand_q [CORE_COUNT];
	map_t pend_w_q;
	map_t hand_w_q;
	rsp_t rsp_q;
	logic rsp_valid_q;

	logic [5:0] me_wide;
	idx_t       me_idx;
	idx_t       tgt_idx;
	logic       req_bad;
	logic       tgt_bad;
	logic       tgt_self;
	map_t       pend_me;
	map_t       hand_me;
	idx_t       low_pend;
	idx_t       low_hand;
	logic       out_free;
	logic       do_notify;
	logic       do_drop;
	rsp_t       single;
	rsp_t       rsp_next;

	assign me_wide  = {2'b00, req_q.requester_core};
	assign me_idx   = me_wide[CORE_IDX_W-1:0];
	assign tgt_idx  = req_q.target_core[CORE_IDX_W-1:0];
	assign req_bad  = me_wide >= CORE_LIMIT;
	assign tgt_bad  = req_q.target_core >= CORE_LIMIT;
	assign tgt_self = req_q.target_core == me_wide;
	assign pend_me  = pend_q[me_idx];
	assign hand_me  = hand_q[me_idx];
	assign low_pend = lowest_idx(pend_w_q);
	assign low_hand = lowest_idx(hand_w_q);
	assign out_free = !rsp_valid_q || !rsp_stall;

	assign do_notify = cmd.emit_single && !req_bad && req_q.command == CMD_NOTIFY
		&& !tgt_bad && !tgt_self;
	assign do_drop   = cmd.emit_single && !req_bad && req_q.command == CMD_DROP;

	always_comb begin
		single = '{status: ST_OK, is_dispatch: 1'b0, source_core: 4'd0,
			dropped_mask: 16'd0, last: 1'b1};
		if (req_bad) begin
			single.status = ST_BAD_TARGET;
		end else begin
			case (req_q.command)
				CMD_NOTIFY: begin
					if (tgt_bad) begin
						single.status = ST_BAD_TARGET;
					end else if (tgt_self) begin
						single.status = ST_SELF;
					end
				end
				CMD_DROP: single.dropped_mask = drop_field(pend_me);
				CMD_WAIT: single.status = ST_BLOCK;
				default: ;
			endcase
		end
	end

	always_comb begin
		rsp_next = single;
		if (cmd.emit_disp) begin
			rsp_next = '{status: ST_OK, is_dispatch: 1'b1, source_core: src_field(low_pend),
				dropped_mask: 16'd0, last: 1'b0};
		end else if (cmd.emit_final) begin
			rsp_next = '{status: ST_OK, is_dispatch: 1'b0, source_core: src_field(low_hand),
				dropped_mask: 16'd0, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORE_COUNT; i++) begin
				pend_q[i] <= '0;
				hand_q[i] <= '0;
			end
		end else begin
			if (do_notify) begin
				pend_q[tgt_idx] <= pend_q[tgt_idx] | onehot_of(me_idx);
			end else if (do_drop) begin
				pend_q[me_idx] <= '0;
			end else if (cmd.emit_final) begin
				// The walk has moved every pending bit, so the pending map ends empty.
				pend_q[me_idx] <= '0;
				hand_q[me_idx] <= hand_w_q & ~onehot_of(low_hand);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
		if (cmd.work_load) begin
			pend_w_q <= pend_me;
			hand_w_q <= hand_me;
		end else if (cmd.emit_disp) begin
			pend_w_q <= pend_w_q & ~onehot_of(low_pend);
			hand_w_q <= hand_w_q | onehot_of(low_pend);
		end
		if (cmd.emit_single || cmd.emit_disp || cmd.emit_final) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit_single || cmd.emit_disp || cmd.emit_final) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts = '{command: req_q.command, req_bad: req_bad, blocked: pend_me == '0 && hand_me == '0,
		pend_nz: pend_w_q != '0, out_free: out_free};

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_single || cmd.emit_disp || cmd.emit_final) |-> out_free)
		else $error("result written over one still waiting");
	a_disp_has_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_disp |-> pend_w_q != '0)
		else $error("dispatch with no pending bit");
	a_final_has_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_final |-> (hand_w_q != '0 && pend_w_q == '0))
		else $error("final reply of wait with no handled bit or bits still pending");
	a_last_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.last != rsp_q.is_dispatch))
		else $error("dispatch and last flags disagree");
`endif

endmodule

// ===== sv/ied_ctrl.sv =====
module ied_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  ied_pkg::dp_sts_t sts,
	output ied_pkg::dp_cmd_t cmd
);
	import ied_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_next   = S_EVAL;
				end
			end
			S_EVAL: begin
				// A wait with something to do walks the maps; all else is one reply.
				if (sts.command == CMD_WAIT && !sts.req_bad && !sts.blocked) begin
					cmd.work_load = 1'b1;
					state_next    = S_WALK;
				end else if (sts.out_free) begin
					cmd.emit_single = 1'b1;
					state_next      = S_IDLE;
				end
			end
			S_WALK: begin
				if (sts.out_free) begin
					if (sts.pend_nz) begin
						cmd.emit_disp = 1'b1;
					end else begin
						cmd.emit_final = 1'b1;
						state_next     = S_IDLE;
					end
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// ===== sv/intercore_event_doorbell_unit.sv =====
// Inter-core event doorbell table: each core has a pending and a handled bitmap indexed by
// sender. A request transaction is taken only when the unit is free, one at a time. Notify,
// drop, a blocked wait and every rejected request give one reply, loaded into the output
// register once that register is free. A wait with n pending senders first fetches the
// requester's maps, then gives one dispatch result per cycle while the result side does not
// stall, and a final reply, paced by the single output register. The request channel is
// held off while a request is in work, but a finished reply may wait in the output register
// while the next request is taken.
module intercore_event_doorbell_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ied_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ied_pkg::rsp_t rsp
);
	import ied_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	ied_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ied_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ===== bench/doorbell_checker.sv =====
`timescale 1ns / 1ps
module doorbell_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  ied_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  ied_pkg::rsp_t rsp,
	output int            mismatches,
	output int            outstanding,
	output int            replies_seen,
	output int            dispatches_seen
);
	import ied_pkg::*;

	map_t pending_map [CORE_COUNT];
	map_t handled_map [CORE_COUNT];
	rsp_t expected_replies [$];

	task automatic add_reply(logic [1:0] status, logic dispatch, logic [3:0] src,
		logic [15:0] dropped, logic last_flag);
		rsp_t item;
		item.status       = status;
		item.is_dispatch  = dispatch;
		item.source_core  = src;
		item.dropped_mask = dropped;
		item.last         = last_flag;
		expected_replies.push_back(item);
	endtask

	// Works out every reply one request transaction causes and updates the table copy.
	task automatic predict_request(req_t r);
		map_t pend;
		map_t hand;
		int   me;
		int   cleared;
		bit   found;
		me = int'(r.requester_core);
		if (me >= CORE_COUNT) begin
			add_reply(ST_BAD_TARGET, 1'b0, 4'd0, 16'd0, 1'b1);
			return;
		end
		case (r.command)
			CMD_NOTIFY: begin
				// The range check wins over the self check.
				if (int'(r.target_core) >= CORE_COUNT) begin
					add_reply(ST_BAD_TARGET, 1'b0, 4'd0, 16'd0, 1'b1);
				end else if (int'(r.target_core) == me) begin
					add_reply(ST_SELF, 1'b0, 4'd0, 16'd0, 1'b1);
				end else begin
					pending_map[r.target_core][me] = 1'b1;
					add_reply(ST_OK, 1'b0, 4'd0, 16'd0, 1'b1);
				end
			end
			CMD_DROP: begin
				add_reply(ST_OK, 1'b0, 4'd0, 16'(pending_map[me]), 1'b1);
				pending_map[me] = '0;
			end
			CMD_WAIT: begin
				pend = pending_map[me];
				hand = handled_map[me];
				if (pend == '0 && hand == '0) begin
					add_reply(ST_BLOCK, 1'b0, 4'd0, 16'd0, 1'b1);
				end else begin
					for (int i = 0; i < CORE_COUNT; i++) begin
						if (pend[i]) begin
							hand[i] = 1'b1;
							add_reply(ST_OK, 1'b1, 4'(i), 16'd0, 1'b0);
						end
					end
					cleared = 0;
					found   = 1'b0;
					for (int i = 0; i < CORE_COUNT; i++) begin
						if (hand[i] && !found) begin
							hand[i] = 1'b0;
							cleared = i;
							found   = 1'b1;
						end
					end
					pending_map[me] = '0;
					handled_map[me] = hand;
					add_reply(ST_OK, 1'b0, 4'(cleared), 16'd0, 1'b1);
				end
			end
			default: begin
				add_reply(ST_OK, 1'b0, 4'd0, 16'd0, 1'b1);
			end
		endcase
	endtask

	always @(posedge clk) begin : watch
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < CORE_COUNT; i++) begin
				pending_map[i] = '0;
				handled_map[i] = '0;
			end
			expected_replies.delete();
			mismatches      = 0;
			replies_seen    = 0;
			dispatches_seen = 0;
		end else begin
			// A reply accepted at this edge always belongs to an earlier request.
			if (rsp_valid && !rsp_stall) begin
				replies_seen++;
				if (rsp.is_dispatch === 1'b1) begin
					dispatches_seen++;
				end
				if (expected_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected reply status=%0d disp=%0d src=%0d drop=%h last=%0d",
							$realtime, rsp.status, rsp.is_dispatch, rsp.source_core,
							rsp.dropped_mask, rsp.last);
					end
				end else begin
					want = expected_replies.pop_front();
					if (rsp.status !== want.status || rsp.is_dispatch !== want.is_dispatch
						|| rsp.source_core !== want.source_core
						|| rsp.dropped_mask !== want.dropped_mask || rsp.last !== want.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch, expected status=%0d disp=%0d src=%0d drop=%h last=%0d",
								$realtime, want.status, want.is_dispatch, want.source_core,
								want.dropped_mask, want.last);
							$display("%0t:           actual   status=%0d disp=%0d src=%0d drop=%h last=%0d",
								$realtime, rsp.status, rsp.is_dispatch, rsp.source_core,
								rsp.dropped_mask, rsp.last);
						end
					end
				end
			end
			if (req_valid && !req_stall) begin
				predict_request(req);
			end
		end
		outstanding = expected_replies.size();
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import ied_pkg::*;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int RANDOM_ITEMS  = 300;
	localparam int HOLD_CYCLES   = 150;
	localparam int SETTLE_CYCLES = 24;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic req_taken    = 1'b0;
	bit   hold_request = 1'b0;
	int   hold_left    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   items_sent   = 0;
	int   cycle_count  = 0;
	int   mismatches;
	int   outstanding;
	int   replies_seen;
	int   dispatches_seen;

	intercore_event_doorbell_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	doorbell_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req             (req),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.rsp             (rsp),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.replies_seen    (replies_seen),
		.dispatches_seen (dispatches_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		req_taken <= req_valid && (req_stall === 1'b0);
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Reply side: random stalls, or one long hold-off when asked for.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			rsp_stall = 1'b1;
			hold_left--;
		end else begin
			rsp_stall = ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_request(logic [1:0] cmd, logic [3:0] who, logic [5:0] dest);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid          = 1'b1;
		req.command        = cmd;
		req.requester_core = who;
		req.target_core    = dest;
		@(negedge clk);
		while (!req_taken) begin
			@(negedge clk);
		end
		items_sent++;
	endtask

	task automatic wait_all_replies();
		req_valid = 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	// Mostly a burst of notifies into one core followed at times by a drop on it, then waits on
	// it; the rest is noise with every field random.
	task automatic run_episode();
		logic [3:0] dest;
		int         kind;
		int         count;
		kind = $urandom_range(9);
		dest = 4'($urandom_range(CORE_COUNT - 1));
		if (kind <= 6) begin
			count = ($urandom_range(7) == 0) ? CORE_COUNT - 1 : $urandom_range(1, 6);
			for (int k = 0; k < count; k++) begin
				if (count == CORE_COUNT - 1) begin
					send_request(CMD_NOTIFY, 4'((int'(dest) + 1 + k) % CORE_COUNT), 6'(dest));
				end else begin
					send_request(CMD_NOTIFY,
						4'((int'(dest) + $urandom_range(1, CORE_COUNT - 1)) % CORE_COUNT),
						6'(dest));
				end
			end
			if (kind >= 5) begin
				send_request(CMD_DROP, dest, 6'($urandom()));
			end
			repeat ($urandom_range(1, 3)) begin
				send_request(CMD_WAIT, dest, 6'($urandom()));
			end
		end else begin
			send_request(2'($urandom_range(3)), 4'($urandom()), 6'($urandom()));
		end
	endtask

	initial begin : stimulus
		int stop_at;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: empty wait, self and out-of-range targets, dispatch order,
		// drop with and without pending bits, and the unused command.
		send_request(CMD_WAIT,   4'd0,  6'd0);
		send_request(CMD_NOTIFY, 4'd1,  6'd0);
		send_request(CMD_NOTIFY, 4'd15, 6'd0);
		send_request(CMD_NOTIFY, 4'd3,  6'd0);
		send_request(CMD_NOTIFY, 4'd5,  6'd5);
		send_request(CMD_NOTIFY, 4'd2,  6'd16);
		send_request(CMD_NOTIFY, 4'd2,  6'd63);
		send_request(CMD_NOTIFY, 4'd15, 6'd15);
		send_request(CMD_NOTIFY, 4'd0,  6'd15);
		send_request(CMD_NOTIFY, 4'd14, 6'd15);
		send_request(CMD_WAIT,   4'd0,  6'd63);
		send_request(CMD_WAIT,   4'd0,  6'd0);
		send_request(CMD_DROP,   4'd15, 6'd0);
		send_request(CMD_DROP,   4'd15, 6'd63);
		send_request(CMD_SPARE,  4'd15, 6'd63);
		send_request(CMD_WAIT,   4'd15, 6'd0);
		send_request(CMD_WAIT,   4'd0,  6'd0);
		send_request(CMD_WAIT,   4'd0,  6'd0);
		wait_all_replies();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct  = (phase == 0) ? 18 : (phase == 1) ? 67 : 0;
			recv_stall_pct = (phase == 0) ? 67 : (phase == 1) ? 18 : 0;
			if (phase == 0) begin
				// Hold the reply side off while requests keep coming, then pause the
				// request side until everything has drained.
				hold_request = 1'b1;
				repeat (4) run_episode();
				wait_all_replies();
			end
			stop_at = items_sent + RANDOM_ITEMS / 3;
			while (items_sent < stop_at) begin
				run_episode();
			end
		end

		wait_all_replies();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Covered %0d requests (directed cases, notify bursts, drops, waits, noise)",
			items_sent);
		$display("and checked %0d replies, %0d of them dispatches, under varied back-pressure.",
			replies_seen, dispatches_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
